[hdl/ppht_pkg.sv]
// Package: sizes, codes and control/status types for the perturbed probe hash table.
package ppht_pkg;

	localparam int INDEX_SLOTS = 32;
	localparam int SLOT_BITS   = $clog2(INDEX_SLOTS);
	localparam int USABLE      = (INDEX_SLOTS * 2) / 3;
	localparam int ENTRY_BITS  = $clog2(USABLE);
	localparam int COUNT_BITS  = 5;
	localparam int IDX_BITS    = 6;
	localparam int KEY_BITS    = 64;
	localparam int HASH_BITS   = 32;
	localparam int VALUE_BITS  = 32;
	localparam int PROBE_SHIFT = 5;
	localparam int ENTRY_WIDTH = KEY_BITS + HASH_BITS + VALUE_BITS;

	// Index slot codes: entry numbers sit below these
	localparam logic [IDX_BITS-1:0] SLOT_EMPTY = {IDX_BITS{1'b1}};
	localparam logic [IDX_BITS-1:0] SLOT_TOMB  = {{(IDX_BITS-1){1'b1}}, 1'b0};

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_EMPTY,
		KIND_TOMB,
		KIND_ENTRY,
		KIND_OTHER
	} slot_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_COMPARE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic note_tomb;
		logic end_empty;
		logic read_entry;
		logic mark_hit;
		logic advance;
		logic commit;
	} cmd_t;

	typedef struct packed {
		slot_kind_t kind;
		logic       match;
		logic       last;
		logic       unused_mode;
	} stat_t;

endpackage

[hdl/ppht_ram.sv]
// Generic single-port-write, registered-read RAM.
module ppht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/ppht_ctrl.sv]
// Controller state machine: sequences probes, compares and the final commit.
module ppht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ppht_pkg::stat_t stat,
	output ppht_pkg::cmd_t  cmd
);

	ppht_pkg::state_t state_q, state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppht_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ppht_pkg::S_IDLE: begin
				if (start) state_n = ppht_pkg::S_PROBE;
			end
			ppht_pkg::S_PROBE: begin
				if (stat.unused_mode) begin
					state_n = ppht_pkg::S_FINISH;
				end else begin
					unique case (stat.kind)
						ppht_pkg::KIND_EMPTY: state_n = ppht_pkg::S_FINISH;
						ppht_pkg::KIND_ENTRY: state_n = ppht_pkg::S_COMPARE;
						default: begin
							if (stat.last) state_n = ppht_pkg::S_FINISH;
						end
					endcase
				end
			end
			ppht_pkg::S_COMPARE: begin
				if (stat.match || stat.last) state_n = ppht_pkg::S_FINISH;
				else state_n = ppht_pkg::S_PROBE;
			end
			ppht_pkg::S_FINISH: state_n = ppht_pkg::S_IDLE;
			default: state_n = ppht_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd  = '0;
		busy = (state_q != ppht_pkg::S_IDLE);
		unique case (state_q)
			ppht_pkg::S_IDLE: begin
				cmd.load = start;
			end
			ppht_pkg::S_PROBE: begin
				if (!stat.unused_mode) begin
					unique case (stat.kind)
						ppht_pkg::KIND_EMPTY: cmd.end_empty = 1'b1;
						ppht_pkg::KIND_ENTRY: cmd.read_entry = 1'b1;
						ppht_pkg::KIND_TOMB: begin
							cmd.note_tomb = 1'b1;
							cmd.advance   = !stat.last;
						end
						default: cmd.advance = !stat.last;
					endcase
				end
			end
			ppht_pkg::S_COMPARE: begin
				cmd.mark_hit = stat.match;
				cmd.advance  = !stat.match && !stat.last;
			end
			ppht_pkg::S_FINISH: begin
				cmd.commit = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[hdl/ppht_datapath.sv]
// Datapath: request registers, index array, probe arithmetic, entry RAM and results.
module ppht_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ppht_pkg::cmd_t                      cmd,
	output ppht_pkg::stat_t                     stat,
	input  logic [1:0]                          mode,
	input  logic [ppht_pkg::KEY_BITS-1:0]       key,
	input  logic [ppht_pkg::HASH_BITS-1:0]      key_hash,
	input  logic [ppht_pkg::VALUE_BITS-1:0]     insert_value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [ppht_pkg::VALUE_BITS-1:0]     found_value,
	output logic [ppht_pkg::COUNT_BITS-1:0]     live_count
);

	// Request registers
	ppht_pkg::mode_t                       mode_q;
	logic [ppht_pkg::KEY_BITS-1:0]         key_q;
	logic [ppht_pkg::HASH_BITS-1:0]        hash_q;
	logic [ppht_pkg::VALUE_BITS-1:0]       value_q;

	// Probe state
	logic [ppht_pkg::SLOT_BITS-1:0]        slot_q;
	logic [ppht_pkg::HASH_BITS-1:0]        pert_q;
	logic [ppht_pkg::SLOT_BITS-1:0]        cnt_q;
	logic [ppht_pkg::SLOT_BITS-1:0]        tomb_q;
	logic                                  tomb_ok_q;
	logic                                  hit_q;
	logic                                  end_empty_q;
	logic [ppht_pkg::ENTRY_BITS-1:0]       entry_q;
	logic [ppht_pkg::VALUE_BITS-1:0]       hit_value_q;

	// Table state
	logic [ppht_pkg::IDX_BITS-1:0]         index_q [ppht_pkg::INDEX_SLOTS];
	logic [ppht_pkg::COUNT_BITS-1:0]       used_q;
	logic [ppht_pkg::COUNT_BITS-1:0]       removed_q;

	// Result registers
	logic                                  done_q;
	ppht_pkg::status_t                     status_q;
	logic [ppht_pkg::VALUE_BITS-1:0]       found_q;
	logic [ppht_pkg::COUNT_BITS-1:0]       live_q;

	logic [ppht_pkg::IDX_BITS-1:0]         idx_cur;
	ppht_pkg::slot_kind_t                  kind_cur;
	logic [ppht_pkg::HASH_BITS-1:0]        pert_n;
	logic [ppht_pkg::SLOT_BITS-1:0]        slot_n;
	logic [ppht_pkg::ENTRY_WIDTH-1:0]      rdata;
	logic [ppht_pkg::KEY_BITS-1:0]         rd_key;
	logic [ppht_pkg::HASH_BITS-1:0]        rd_hash;
	logic [ppht_pkg::VALUE_BITS-1:0]       rd_value;

	logic [ppht_pkg::SLOT_BITS-1:0]        where;
	logic                                  where_ok;
	logic                                  ram_we;
	logic [ppht_pkg::ENTRY_BITS-1:0]       ram_waddr;
	logic                                  idx_we;
	logic [ppht_pkg::SLOT_BITS-1:0]        idx_waddr;
	logic [ppht_pkg::IDX_BITS-1:0]         idx_wdata;
	logic [ppht_pkg::COUNT_BITS-1:0]       used_n;
	logic [ppht_pkg::COUNT_BITS-1:0]       removed_n;
	ppht_pkg::status_t                     status_n;
	logic [ppht_pkg::VALUE_BITS-1:0]       found_n;

	// Classify the slot under the probe
	assign idx_cur = index_q[slot_q];
	always_comb begin
		if (idx_cur == ppht_pkg::SLOT_EMPTY) begin
			kind_cur = ppht_pkg::KIND_EMPTY;
		end else if (idx_cur == ppht_pkg::SLOT_TOMB) begin
			kind_cur = ppht_pkg::KIND_TOMB;
		end else if (!idx_cur[ppht_pkg::IDX_BITS-1] &&
			(32'(idx_cur) < 32'(ppht_pkg::USABLE))) begin
			kind_cur = ppht_pkg::KIND_ENTRY;
		end else begin
			kind_cur = ppht_pkg::KIND_OTHER;
		end
	end
	assign stat.kind = kind_cur;

	// Compare the fetched entry against the request
	assign rd_key   = rdata[ppht_pkg::ENTRY_WIDTH-1 -: ppht_pkg::KEY_BITS];
	assign rd_hash  = rdata[ppht_pkg::VALUE_BITS +: ppht_pkg::HASH_BITS];
	assign rd_value = rdata[ppht_pkg::VALUE_BITS-1:0];
	assign stat.match       = (rd_key == key_q) && (rd_hash == hash_q);
	assign stat.last        = (cnt_q == ppht_pkg::SLOT_BITS'(ppht_pkg::INDEX_SLOTS - 1));
	assign stat.unused_mode = (mode_q == ppht_pkg::MODE_UNUSED);

	// Next probe slot: 5 * slot + (perturb >> shift) + 1, wrapped to the index
	assign pert_n = pert_q >> ppht_pkg::PROBE_SHIFT;
	assign slot_n = slot_q + {slot_q[ppht_pkg::SLOT_BITS-3:0], 2'b00} +
		pert_n[ppht_pkg::SLOT_BITS-1:0] + ppht_pkg::SLOT_BITS'(1);

	// Hold request and probe registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= ppht_pkg::mode_t'(mode);
			key_q   <= key;
			hash_q  <= key_hash;
			value_q <= insert_value;
			slot_q  <= key_hash[ppht_pkg::SLOT_BITS-1:0];
			pert_q  <= key_hash;
			cnt_q   <= '0;
		end else if (cmd.advance) begin
			slot_q <= slot_n;
			pert_q <= pert_n;
			cnt_q  <= cnt_q + ppht_pkg::SLOT_BITS'(1);
		end
		if (cmd.note_tomb && !tomb_ok_q) begin
			tomb_q <= slot_q;
		end
		if (cmd.read_entry) begin
			entry_q <= idx_cur[ppht_pkg::ENTRY_BITS-1:0];
		end
		if (cmd.mark_hit) begin
			hit_value_q <= rd_value;
		end
	end

	// Probe outcome flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tomb_ok_q   <= 1'b0;
			hit_q       <= 1'b0;
			end_empty_q <= 1'b0;
		end else if (cmd.load) begin
			tomb_ok_q   <= 1'b0;
			hit_q       <= 1'b0;
			end_empty_q <= 1'b0;
		end else begin
			if (cmd.note_tomb) tomb_ok_q <= 1'b1;
			if (cmd.mark_hit) hit_q <= 1'b1;
			if (cmd.end_empty) end_empty_q <= 1'b1;
		end
	end

	// Pick the placement slot for an absent key
	always_comb begin
		if (end_empty_q && !tomb_ok_q) begin
			where    = slot_q;
			where_ok = 1'b1;
		end else begin
			where    = tomb_q;
			where_ok = tomb_ok_q;
		end
	end

	// Decide the commit: writes, counters and the result
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = entry_q;
		idx_we    = 1'b0;
		idx_waddr = slot_q;
		idx_wdata = ppht_pkg::SLOT_TOMB;
		used_n    = used_q;
		removed_n = removed_q;
		status_n  = ppht_pkg::ST_DONE;
		found_n   = '0;
		unique case (mode_q)
			ppht_pkg::MODE_LOOKUP: begin
				if (hit_q) found_n = hit_value_q;
				else status_n = ppht_pkg::ST_NOTFOUND;
			end
			ppht_pkg::MODE_INSERT: begin
				if (hit_q) begin
					ram_we = 1'b1;
				end else if (!where_ok ||
					(32'(used_q) >= 32'(ppht_pkg::USABLE))) begin
					status_n = ppht_pkg::ST_FULL;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = used_q[ppht_pkg::ENTRY_BITS-1:0];
					idx_we    = 1'b1;
					idx_waddr = where;
					idx_wdata = ppht_pkg::IDX_BITS'(used_q);
					used_n    = used_q + ppht_pkg::COUNT_BITS'(1);
				end
			end
			ppht_pkg::MODE_REMOVE: begin
				if (hit_q) begin
					idx_we    = 1'b1;
					removed_n = removed_q + ppht_pkg::COUNT_BITS'(1);
				end
			end
			ppht_pkg::MODE_UNUSED: begin
				status_n = ppht_pkg::ST_DONE;
			end
			default: status_n = ppht_pkg::ST_DONE;
		endcase
		if (!cmd.commit) begin
			ram_we = 1'b0;
			idx_we = 1'b0;
		end
	end

	// Index array and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppht_pkg::INDEX_SLOTS; i++) begin
				index_q[i] <= ppht_pkg::SLOT_EMPTY;
			end
			used_q    <= '0;
			removed_q <= '0;
		end else if (cmd.commit) begin
			if (idx_we) index_q[idx_waddr] <= idx_wdata;
			used_q    <= used_n;
			removed_q <= removed_n;
		end
	end

	// Result registers: one-cycle strobe after commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_n;
			found_q  <= found_n;
			live_q   <= used_n - removed_n;
		end
	end

	// Entry storage: key, hash and value per appended entry
	ppht_ram #(
		.WIDTH(ppht_pkg::ENTRY_WIDTH),
		.DEPTH(ppht_pkg::USABLE)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({key_q, hash_q, value_q}),
		.re   (cmd.read_entry),
		.raddr(idx_cur[ppht_pkg::ENTRY_BITS-1:0]),
		.rdata(rdata)
	);

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign live_count  = live_q;

endmodule

[hdl/perturbed_probe_hash_table.sv]
// Top level: compact open-addressing hash table with perturbed probing.
//
// Usage:
//   Requests enter on start/busy: a transfer happens at a rising edge with
//   start high and busy low; mode, key, key_hash and insert_value are sampled
//   then. Each request yields exactly one result: done is high for one
//   cycle with status, found_value and live_count valid in that cycle.
//   The receiver cannot stall, so results are never held back.
//   Sequence: after the transfer, a probe of an empty or tombstone slot uses
//   the probe state alone, and a probe of an occupied slot uses the probe
//   state (index read) and then the compare state (registered entry RAM read
//   and key compare); then come the commit state and the done cycle. busy is
//   already low in the done cycle, so the next request can transfer at the
//   edge that ends it. An unused mode passes through the probe state without
//   probing. The registered entry RAM read port is why an occupied slot needs
//   the compare state.
//   Reset empties every index slot and clears both entry counters at once;
//   the entry RAM is not cleared, as only appended entries are ever read.
module perturbed_probe_hash_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic [ppht_pkg::KEY_BITS-1:0]       key,
	input  logic [ppht_pkg::HASH_BITS-1:0]      key_hash,
	input  logic [ppht_pkg::VALUE_BITS-1:0]     insert_value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [ppht_pkg::VALUE_BITS-1:0]     found_value,
	output logic [ppht_pkg::COUNT_BITS-1:0]     live_count
);

	ppht_pkg::cmd_t  cmd;
	ppht_pkg::stat_t stat;

	// Sequencer
	ppht_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	// Storage and arithmetic
	ppht_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.key         (key),
		.key_hash    (key_hash),
		.insert_value(insert_value),
		.done        (done),
		.status      (status),
		.found_value (found_value),
		.live_count  (live_count)
	);

endmodule

[tb/sv/perturbed_probe_hash_table_tb.sv]
// Testbench for the perturbed probe hash table: directed table, then pooled random requests.
module perturbed_probe_hash_table_tb;

	localparam int RESET_CYCLES   = 5;
	localparam int PLAN_ROWS      = 22;
	localparam int RANDOM_ITEMS   = 1430;
	localparam int QUIET_ITEMS    = 150;
	localparam int POOL_SIZE      = 32;
	localparam int TAIL_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [31:0] SLOT_MASK = ppht_pkg::INDEX_SLOTS - 1;

	typedef struct packed {
		ppht_pkg::status_t st;
		logic [31:0]       fv;
		logic [4:0]        lc;
	} answer_t;

	typedef struct packed {
		ppht_pkg::mode_t op;
		logic [63:0]     k;
		logic [31:0]     h;
		logic [31:0]     v;
		logic            typed;
		answer_t         ans;
	} plan_row_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  start = 1'b0;
	logic                                  busy;
	logic [1:0]                            mode = ppht_pkg::MODE_LOOKUP;
	logic [ppht_pkg::KEY_BITS-1:0]         key = '0;
	logic [ppht_pkg::HASH_BITS-1:0]        key_hash = '0;
	logic [ppht_pkg::VALUE_BITS-1:0]       insert_value = '0;
	logic                                  done;
	logic [1:0]                            status;
	logic [ppht_pkg::VALUE_BITS-1:0]       found_value;
	logic [ppht_pkg::COUNT_BITS-1:0]       live_count;

	// Typed expectation that travels with the request on the ports
	logic                                  plan_known = 1'b0;
	answer_t                               plan_answer = '0;

	// Shadow copy of the table
	logic [ppht_pkg::IDX_BITS-1:0]         slot_map [ppht_pkg::INDEX_SLOTS];
	logic [63:0]                           stored_key [ppht_pkg::USABLE];
	logic [31:0]                           stored_hash [ppht_pkg::USABLE];
	logic [31:0]                           stored_value [ppht_pkg::USABLE];
	int                                    appended;
	int                                    removed_total;

	answer_t                               pending_answers [$];
	plan_row_t                             plan [PLAN_ROWS];
	int                                    failures = 0;
	int                                    idle_cycles = 0;

	perturbed_probe_hash_table dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Probe the shadow table, apply the request and return the answer it gives
	function automatic answer_t apply_request(ppht_pkg::mode_t op, logic [63:0] k,
			logic [31:0] h, logic [31:0] v);
		answer_t a;
		logic [31:0] slot, pert, tomb_at;
		logic [ppht_pkg::IDX_BITS-1:0] e, hit_entry;
		logic hit, seen_tomb, stop, have_place;
		int i;
		a = '{ppht_pkg::ST_DONE, 32'h0, 5'd0};
		slot = h & SLOT_MASK;
		pert = h;
		tomb_at = '0;
		hit_entry = '0;
		hit = 1'b0;
		seen_tomb = 1'b0;
		stop = 1'b0;
		for (i = 0; i < ppht_pkg::INDEX_SLOTS; i++) begin
			if (!stop) begin
				e = slot_map[slot[ppht_pkg::SLOT_BITS-1:0]];
				if (e == ppht_pkg::SLOT_TOMB && !seen_tomb) begin
					seen_tomb = 1'b1;
					tomb_at = slot;
				end
				if (e == ppht_pkg::SLOT_EMPTY) begin
					stop = 1'b1;
				end else if (e < ppht_pkg::USABLE && stored_hash[e] == h &&
						stored_key[e] == k) begin
					stop = 1'b1;
					hit = 1'b1;
					hit_entry = e;
				end else begin
					pert = pert >> ppht_pkg::PROBE_SHIFT;
					slot = (5 * slot + pert + 1) & SLOT_MASK;
				end
			end
		end
		// a probe that ran out of slots may still place at the first tombstone
		have_place = stop || seen_tomb;
		if (!hit && seen_tomb)
			slot = tomb_at;

		case (op)
			ppht_pkg::MODE_LOOKUP: begin
				if (hit)
					a.fv = stored_value[hit_entry];
				else
					a.st = ppht_pkg::ST_NOTFOUND;
			end
			ppht_pkg::MODE_INSERT: begin
				if (hit) begin
					stored_value[hit_entry] = v;
				end else if (!have_place || appended >= ppht_pkg::USABLE) begin
					a.st = ppht_pkg::ST_FULL;
				end else begin
					stored_key[appended] = k;
					stored_hash[appended] = h;
					stored_value[appended] = v;
					slot_map[slot[ppht_pkg::SLOT_BITS-1:0]] =
						ppht_pkg::IDX_BITS'(appended);
					appended++;
				end
			end
			ppht_pkg::MODE_REMOVE: begin
				if (hit) begin
					slot_map[slot[ppht_pkg::SLOT_BITS-1:0]] = ppht_pkg::SLOT_TOMB;
					removed_total++;
				end
			end
			default: ;
		endcase
		a.lc = 5'(appended - removed_total);
		return a;
	endfunction

	task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// Check results, record accepted requests and watch for a stall
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_answers.size() == 0) begin
					failures++;
					$display("%0t: result expected none actual status %0d value %0h count %0d",
						$time, status, found_value, live_count);
				end else begin
					want = pending_answers.pop_front();
					compare_field("status", 32'(want.st), 32'(status));
					compare_field("found_value", want.fv, found_value);
					compare_field("live_count", 32'(want.lc), 32'(live_count));
				end
			end
			if (start && !busy) begin
				want = apply_request(ppht_pkg::mode_t'(mode), key, key_hash, insert_value);
				if (plan_known)
					want = plan_answer;
				pending_answers.push_back(want);
			end
			if (done || (start && !busy)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles == WATCHDOG_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// Present one request and hold it until the transfer
	task automatic offer(ppht_pkg::mode_t op, logic [63:0] k, logic [31:0] h,
			logic [31:0] v, logic typed, answer_t ans);
		start <= 1'b1;
		mode <= op;
		key <= k;
		key_hash <= h;
		insert_value <= v;
		plan_known <= typed;
		plan_answer <= ans;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	initial begin
		logic [63:0] pool_key [POOL_SIZE];
		logic [31:0] pool_hash [POOL_SIZE];
		logic [63:0] k;
		logic [31:0] h;
		logic [1:0] pick;
		ppht_pkg::mode_t op;
		answer_t blank;
		int n, p, r, idle_odds;

		blank = '{ppht_pkg::ST_DONE, 32'h0, 5'd0};
		for (n = 0; n < ppht_pkg::INDEX_SLOTS; n++)
			slot_map[n] = ppht_pkg::SLOT_EMPTY;
		for (n = 0; n < ppht_pkg::USABLE; n++) begin
			stored_key[n] = '0;
			stored_hash[n] = '0;
			stored_value[n] = '0;
		end
		appended = 0;
		removed_total = 0;

		// Directed table: empty table, extremes, collisions, tombstone reuse
		plan[0]  = '{ppht_pkg::MODE_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b1,
			'{ppht_pkg::ST_NOTFOUND, 32'h0, 5'd0}};
		plan[1]  = '{ppht_pkg::MODE_REMOVE, '1, '1, '1, 1'b1,
			'{ppht_pkg::ST_DONE, 32'h0, 5'd0}};
		plan[2]  = '{ppht_pkg::MODE_UNUSED, '1, '1, '1, 1'b1,
			'{ppht_pkg::ST_DONE, 32'h0, 5'd0}};
		plan[3]  = '{ppht_pkg::MODE_INSERT, 64'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
			'{ppht_pkg::ST_DONE, 32'h0, 5'd1}};
		plan[4]  = '{ppht_pkg::MODE_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b1,
			'{ppht_pkg::ST_DONE, 32'hFFFF_FFFF, 5'd1}};
		plan[5]  = '{ppht_pkg::MODE_INSERT, '1, '1, 32'h0, 1'b1,
			'{ppht_pkg::ST_DONE, 32'h0, 5'd2}};
		plan[6]  = '{ppht_pkg::MODE_LOOKUP, '1, '1, '1, 1'b1,
			'{ppht_pkg::ST_DONE, 32'h0, 5'd2}};
		plan[7]  = '{ppht_pkg::MODE_INSERT, 64'h1, 32'h0, 32'h5, 1'b0, blank};
		plan[8]  = '{ppht_pkg::MODE_LOOKUP, 64'h1, 32'h0, 32'h0, 1'b0, blank};
		plan[9]  = '{ppht_pkg::MODE_INSERT, 64'h0, 32'h0, 32'h1234, 1'b0, blank};
		plan[10] = '{ppht_pkg::MODE_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b0, blank};
		plan[11] = '{ppht_pkg::MODE_LOOKUP, 64'h2, 32'h0, 32'h0, 1'b0, blank};
		plan[12] = '{ppht_pkg::MODE_LOOKUP, 64'h0, 32'h1, 32'h0, 1'b0, blank};
		plan[13] = '{ppht_pkg::MODE_REMOVE, 64'h0, 32'h0, 32'h0, 1'b0, blank};
		plan[14] = '{ppht_pkg::MODE_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b0, blank};
		plan[15] = '{ppht_pkg::MODE_LOOKUP, 64'h1, 32'h0, 32'h0, 1'b0, blank};
		plan[16] = '{ppht_pkg::MODE_INSERT, 64'h3, 32'h0, 32'h7, 1'b0, blank};
		plan[17] = '{ppht_pkg::MODE_LOOKUP, 64'h3, 32'h0, 32'h0, 1'b0, blank};
		plan[18] = '{ppht_pkg::MODE_REMOVE, 64'h1, 32'h0, 32'h0, 1'b0, blank};
		plan[19] = '{ppht_pkg::MODE_UNUSED, 64'h5, 32'h5, 32'h5, 1'b1,
			'{ppht_pkg::ST_DONE, 32'h0, 5'd2}};
		plan[20] = '{ppht_pkg::MODE_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b0, blank};
		plan[21] = '{ppht_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0000, 32'h8000_0000,
			32'h0, 1'b0, blank};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < PLAN_ROWS; n++) begin
			if ($urandom_range(0, 3) == 0)
				pause($urandom_range(1, 8));
			offer(plan[n].op, plan[n].k, plan[n].h, plan[n].v, plan[n].typed, plan[n].ans);
		end
		drain();

		// Build a key pool whose hashes collide often: shared hashes and crowded low bits
		for (n = 0; n < POOL_SIZE; n++) begin
			pool_key[n] = {$urandom, $urandom};
			r = $urandom_range(0, 2);
			if (r == 0 && n > 0)
				pool_hash[n] = pool_hash[$urandom_range(0, n - 1)];
			else if (r == 1)
				pool_hash[n] = ($urandom & ~SLOT_MASK) | $urandom_range(0, 3);
			else
				pool_hash[n] = $urandom;
		end

		idle_odds = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				idle_odds = $urandom_range(0, 2);
			if (n == RANDOM_ITEMS / 2)
				drain();
			if (n < RANDOM_ITEMS - QUIET_ITEMS &&
					((idle_odds == 1 && $urandom_range(0, 7) == 0) ||
					(idle_odds == 2 && $urandom_range(0, 1) == 0)))
				pause($urandom_range(1, 8));

			// Mostly pool traffic, some unused mode and near-miss noise
			p = $urandom_range(0, POOL_SIZE - 1);
			k = pool_key[p];
			h = pool_hash[p];
			r = $urandom_range(0, 99);
			if (r < 40) begin
				op = ppht_pkg::MODE_LOOKUP;
			end else if (r < 65) begin
				op = ppht_pkg::MODE_INSERT;
			end else if (r < 77) begin
				op = ppht_pkg::MODE_REMOVE;
			end else if (r < 82) begin
				op = ppht_pkg::MODE_UNUSED;
				k = {$urandom, $urandom};
				h = $urandom;
			end else begin
				pick = 2'($urandom_range(0, 2));
				op = ppht_pkg::mode_t'(pick);
				if ($urandom_range(0, 1) == 0)
					k = {$urandom, $urandom};
				else
					h = $urandom;
			end
			offer(op, k, h, $urandom, 1'b0, blank);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hdl/ppht_pkg.sv
hdl/ppht_ram.sv
hdl/ppht_ctrl.sv
hdl/ppht_datapath.sv
hdl/perturbed_probe_hash_table.sv
tb/sv/perturbed_probe_hash_table_tb.sv
